// ===== hdl/grre_pkg.sv =====
// Shared constants, types and glyph font tables for the glyph run rectangle emitter.
package grre_pkg;

    // Coordinate and glyph geometry.
    localparam int COORD_BITS    = 16;
    localparam int GLYPH_ROWS    = 7;
    localparam int GLYPH_COLS    = 5;
    localparam int NUM_GLYPHS    = 43;
    localparam int CELL_W        = 10;
    localparam int CODE_W        = 8;
    localparam int ADVANCE_CELLS = 6;
    localparam int COL_W         = $clog2(GLYPH_COLS + 1);
    localparam int ROW_W         = $clog2(GLYPH_ROWS + 1);
    localparam int GLYPH_IDX_W   = $clog2(NUM_GLYPHS);
    localparam int PROD_W        = CELL_W + ROW_W;

    // Glyph row memory: one entry per glyph row, rows padded to a power of two.
    localparam int ROM_DEPTH = NUM_GLYPHS << ROW_W;
    localparam int ROM_AW    = $clog2(ROM_DEPTH);

    localparam logic [CELL_W-1:0] DEFAULT_CELL = CELL_W'(32);

    // Configuration port.
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;
    localparam int CFG_IDX_W = CFG_AW - 2;
    localparam logic [CFG_IDX_W-1:0] REG_CELL_SIZE = '0;

    // Character codes of the lower case range and its two exceptions.
    localparam logic [CODE_W-1:0] CODE_LOWER_A = 8'h61;
    localparam logic [CODE_W-1:0] CODE_LOWER_Z = 8'h7A;
    localparam logic [CODE_W-1:0] CODE_LOWER_M = 8'h6D;
    localparam logic [CODE_W-1:0] CODE_LOWER_S = 8'h73;
    localparam logic [CODE_W-1:0] CASE_OFFSET  = 8'h20;

    typedef struct packed {
        logic                   hit;
        logic [GLYPH_IDX_W-1:0] idx;
    } t_glyph_hit;

    typedef struct packed {
        logic                  we;
        logic [ROM_AW-1:0]     waddr;
        logic [GLYPH_COLS-1:0] wdata;
        logic [ROM_AW-1:0]     raddr;
    } t_rom_req;

    typedef struct packed {
        logic [COORD_BITS-1:0] left_x;
        logic [COORD_BITS-1:0] top_y;
        logic [COORD_BITS-1:0] right_x;
        logic [COORD_BITS-1:0] bottom_y;
        logic                  last_of_char;
    } t_rect;

    // Character code of each glyph.
    localparam logic [CODE_W-1:0] GLYPH_CODE [NUM_GLYPHS] = '{
        8'h20, 8'h2E, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h46, 8'h50, 8'h53, 8'h4D, 8'h6D, 8'h73, 8'h43, 8'h44,
        8'h45, 8'h57, 8'h4E, 8'h58, 8'h59, 8'h49, 8'h54, 8'h52, 8'h41, 8'h42,
        8'h4B, 8'h56, 8'h47, 8'h48, 8'h4A, 8'h4C, 8'h4F, 8'h51, 8'h55, 8'h5A,
        8'h3A, 8'h2D, 8'h2F
    };

    // Row bitmaps, top row first; bit 4 is the leftmost column.
    localparam logic [GLYPH_COLS-1:0] GLYPH_BITS [NUM_GLYPHS][GLYPH_ROWS] = '{
        '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00},
        '{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h0C, 5'h0C},
        '{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
        '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
        '{5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F},
        '{5'h0E, 5'h11, 5'h01, 5'h06, 5'h01, 5'h11, 5'h0E},
        '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
        '{5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E},
        '{5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
        '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
        '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
        '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C},
        '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10},
        '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10},
        '{5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E},
        '{5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11},
        '{5'h00, 5'h00, 5'h1A, 5'h15, 5'h15, 5'h15, 5'h15},
        '{5'h00, 5'h00, 5'h0F, 5'h10, 5'h0E, 5'h01, 5'h1E},
        '{5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E},
        '{5'h1E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1E},
        '{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F},
        '{5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11},
        '{5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11},
        '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11},
        '{5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04},
        '{5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
        '{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
        '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11},
        '{5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
        '{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E},
        '{5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11},
        '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04},
        '{5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F},
        '{5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
        '{5'h07, 5'h02, 5'h02, 5'h02, 5'h02, 5'h12, 5'h0C},
        '{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},
        '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
        '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D},
        '{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
        '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F},
        '{5'h00, 5'h0C, 5'h0C, 5'h00, 5'h0C, 5'h0C, 5'h00},
        '{5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00},
        '{5'h01, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h10}
    };

    // Folds lower case to upper case, keeping m and s, and finds the glyph.
    function automatic t_glyph_hit glyph_lookup(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] folded;
        t_glyph_hit        res;
        folded = code;
        if (code inside {[CODE_LOWER_A:CODE_LOWER_Z]} &&
            code != CODE_LOWER_M && code != CODE_LOWER_S) begin
            folded = code - CASE_OFFSET;
        end
        res.hit = 1'b0;
        res.idx = '0;
        for (int i = 0; i < NUM_GLYPHS; i++) begin
            if (GLYPH_CODE[i] == folded) begin
                res.hit = 1'b1;
                res.idx = GLYPH_IDX_W'(i);
            end
        end
        return res;
    endfunction

    // Row bitmap of a glyph; padding rows and unused indexes read as blank.
    function automatic logic [GLYPH_COLS-1:0] glyph_row(input logic [GLYPH_IDX_W-1:0] idx,
                                                       input logic [ROW_W-1:0] row);
        logic [GLYPH_COLS-1:0] bits;
        bits = '0;
        if (int'(idx) < NUM_GLYPHS && int'(row) < GLYPH_ROWS) begin
            bits = GLYPH_BITS[idx][row];
        end
        return bits;
    endfunction

    // Lowest row of a glyph that holds a set pixel.
    function automatic logic [ROW_W-1:0] glyph_last_row(input logic [GLYPH_IDX_W-1:0] idx);
        logic [ROW_W-1:0] last;
        last = '0;
        for (int r = 0; r < GLYPH_ROWS; r++) begin
            if (glyph_row(idx, ROW_W'(r)) != '0) begin
                last = ROW_W'(r);
            end
        end
        return last;
    endfunction

endpackage

// ===== hdl/grre_char_if.sv =====
// Character input channel: valid/ready handshake with one text character per item.
interface grre_char_if;
    logic                           valid;
    logic                           ready;
    logic [grre_pkg::CODE_W-1:0]     char_code;
    logic                           start_string;
    logic [grre_pkg::COORD_BITS-1:0] origin_x;
    logic [grre_pkg::COORD_BITS-1:0] origin_y;

    modport source (output valid, output char_code, output start_string,
                    output origin_x, output origin_y, input ready);
    modport sink   (input valid, input char_code, input start_string,
                    input origin_x, input origin_y, output ready);
endinterface

// ===== hdl/grre_rect_if.sv =====
// Rectangle output channel: valid/ready handshake with one rectangle per item.
interface grre_rect_if;
    logic                           valid;
    logic                           ready;
    logic [grre_pkg::COORD_BITS-1:0] left_x;
    logic [grre_pkg::COORD_BITS-1:0] top_y;
    logic [grre_pkg::COORD_BITS-1:0] right_x;
    logic [grre_pkg::COORD_BITS-1:0] bottom_y;
    logic                           last_of_char;

    modport source (output valid, output left_x, output top_y, output right_x,
                    output bottom_y, output last_of_char, input ready);
    modport sink   (input valid, input left_x, input top_y, input right_x,
                    input bottom_y, input last_of_char, output ready);
endinterface

// ===== hdl/grre_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module grre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/grre_cfg.sv =====
// APB-style configuration register block holding the glyph cell size.
module grre_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [grre_pkg::CFG_AW-1:0]   paddr,
    input  logic [grre_pkg::CFG_DW-1:0]   pwdata,
    output logic [grre_pkg::CFG_DW-1:0]   prdata,
    output logic                          pready,
    output logic [grre_pkg::CELL_W-1:0]   o_cell_size
);

    logic [grre_pkg::CELL_W-1:0]    r_cell_size;
    logic [grre_pkg::CFG_IDX_W-1:0] reg_idx;
    logic                           wr_en;

    assign reg_idx = paddr[grre_pkg::CFG_AW-1:2];
    assign wr_en   = psel && penable && pwrite;

    // Cell size register; writes to other addresses are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_size <= grre_pkg::DEFAULT_CELL;
        end else if (wr_en && reg_idx == grre_pkg::REG_CELL_SIZE) begin
            r_cell_size <= pwdata[grre_pkg::CELL_W-1:0];
        end
    end

    // Read data; unmapped addresses read as zero.
    always_comb begin
        prdata = '0;
        if (reg_idx == grre_pkg::REG_CELL_SIZE) begin
            prdata = grre_pkg::CFG_DW'(r_cell_size);
        end
    end

    assign pready      = 1'b1;
    assign o_cell_size = r_cell_size;

endmodule

// ===== hdl/grre_seq.sv =====
// Sequencer: fills the glyph row memory, scans rows into runs and drives the rectangles.
module grre_seq (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [grre_pkg::CELL_W-1:0] i_cell_size,
    grre_char_if.sink                   i_char,
    grre_rect_if.source                 o_rect,
    output grre_pkg::t_rom_req          o_rom_req,
    input  logic [grre_pkg::GLYPH_COLS-1:0] i_rom_rdata
);

    typedef enum logic [2:0] {
        S_FILL,
        S_IDLE,
        S_LOAD,
        S_EMIT,
        S_ADV
    } t_state;

    localparam int CB = grre_pkg::COORD_BITS;
    localparam logic [grre_pkg::ROW_W-1:0] LAST_ROW = grre_pkg::ROW_W'(grre_pkg::GLYPH_ROWS - 1);

    t_state                              r_state;
    logic [grre_pkg::ROM_AW-1:0]         r_fill;
    logic [CB-1:0]                       r_cursor;
    logic [CB-1:0]                       r_origin_y;
    logic [grre_pkg::CELL_W-1:0]         r_cell;
    logic [grre_pkg::GLYPH_IDX_W-1:0]    r_glyph;
    logic [grre_pkg::ROW_W-1:0]          r_row;
    logic [grre_pkg::ROW_W-1:0]          r_last_row;
    logic [grre_pkg::GLYPH_COLS-1:0]     r_bits;
    logic                                r_out_valid;
    grre_pkg::t_rect                     r_out;

    grre_pkg::t_glyph_hit                lookup;
    logic                                accept;
    logic                                out_free;
    logic                                emit;
    logic [grre_pkg::CELL_W-1:0]         cell_eff;
    logic [grre_pkg::COL_W-1:0]          run_start;
    logic [grre_pkg::COL_W-1:0]          run_end;
    logic [grre_pkg::GLYPH_COLS-1:0]     run_rem;
    logic [grre_pkg::PROD_W-1:0]         start_off;
    logic [grre_pkg::PROD_W-1:0]         end_off;
    logic [grre_pkg::PROD_W-1:0]         row_off;
    logic [grre_pkg::PROD_W-1:0]         adv_off;
    logic [CB-1:0]                       top_y;
    logic                                row_done;

    assign lookup   = grre_pkg::glyph_lookup(i_char.char_code);
    assign accept   = i_char.valid && i_char.ready;
    assign out_free = !r_out_valid || o_rect.ready;
    assign cell_eff = (i_cell_size == '0) ? grre_pkg::DEFAULT_CELL : i_cell_size;

    // Leftmost run of set pixels in the remaining row bits, and what is left after it.
    always_comb begin
        logic found;
        logic closed;
        found     = 1'b0;
        closed    = 1'b0;
        run_start = '0;
        run_end   = grre_pkg::COL_W'(grre_pkg::GLYPH_COLS);
        for (int c = 0; c < grre_pkg::GLYPH_COLS; c++) begin
            if (!found && r_bits[grre_pkg::GLYPH_COLS-1-c]) begin
                found     = 1'b1;
                run_start = grre_pkg::COL_W'(c);
            end
        end
        for (int c = 0; c < grre_pkg::GLYPH_COLS; c++) begin
            if (grre_pkg::COL_W'(c) > run_start && !closed &&
                !r_bits[grre_pkg::GLYPH_COLS-1-c]) begin
                closed  = 1'b1;
                run_end = grre_pkg::COL_W'(c);
            end
        end
        run_rem = r_bits & ({grre_pkg::GLYPH_COLS{1'b1}} >> run_end);
    end

    // Small cell multiples for the rectangle edges and the cursor step.
    assign start_off = grre_pkg::PROD_W'(r_cell) * grre_pkg::PROD_W'(run_start);
    assign end_off   = grre_pkg::PROD_W'(r_cell) * grre_pkg::PROD_W'(run_end);
    assign row_off   = grre_pkg::PROD_W'(r_cell) * grre_pkg::PROD_W'(r_row);
    assign adv_off   = grre_pkg::PROD_W'(r_cell) * grre_pkg::PROD_W'(grre_pkg::ADVANCE_CELLS);
    assign top_y     = r_origin_y + CB'(row_off);

    assign emit     = (r_state == S_EMIT) && (r_bits != '0) && out_free;
    assign row_done = (r_bits == '0) || (emit && run_rem == '0);

    // Memory requests: fill writes during the sweep, row reads ahead of the scan.
    always_comb begin
        o_rom_req.we    = (r_state == S_FILL);
        o_rom_req.waddr = r_fill;
        o_rom_req.wdata = grre_pkg::glyph_row(r_fill[grre_pkg::ROM_AW-1:grre_pkg::ROW_W],
                                              r_fill[grre_pkg::ROW_W-1:0]);
        if (r_state == S_IDLE) begin
            o_rom_req.raddr = {lookup.idx, grre_pkg::ROW_W'(0)};
        end else begin
            o_rom_req.raddr = {r_glyph, r_row + grre_pkg::ROW_W'(1)};
        end
    end

    // State machine, cursor and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_fill      <= '0;
            r_cursor    <= '0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A new rectangle fills the output register; a taken one empties it.
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_rect.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_FILL: begin
                    r_fill <= r_fill + grre_pkg::ROM_AW'(1);
                    if (r_fill == grre_pkg::ROM_AW'(grre_pkg::ROM_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        if (i_char.start_string) begin
                            r_cursor <= i_char.origin_x;
                        end
                        r_origin_y <= i_char.origin_y;
                        r_cell     <= cell_eff;
                        r_glyph    <= lookup.idx;
                        r_last_row <= grre_pkg::glyph_last_row(lookup.idx);
                        r_row      <= '0;
                        r_state    <= lookup.hit ? S_LOAD : S_ADV;
                    end
                end
                S_LOAD: begin
                    r_bits  <= i_rom_rdata;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (emit) begin
                        r_bits                <= run_rem;
                        r_out.left_x          <= r_cursor + CB'(start_off);
                        r_out.right_x         <= r_cursor + CB'(end_off);
                        r_out.top_y           <= top_y;
                        r_out.bottom_y        <= top_y + CB'(r_cell);
                        r_out.last_of_char    <= (r_row == r_last_row) && (run_rem == '0);
                    end
                    if (row_done) begin
                        if (r_row == LAST_ROW) begin
                            r_state <= S_ADV;
                        end else begin
                            r_row   <= r_row + grre_pkg::ROW_W'(1);
                            r_state <= S_LOAD;
                        end
                    end
                end
                S_ADV: begin
                    r_cursor <= r_cursor + CB'(adv_off);
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_char.ready        = (r_state == S_IDLE);
    assign o_rect.valid        = r_out_valid;
    assign o_rect.left_x       = r_out.left_x;
    assign o_rect.top_y        = r_out.top_y;
    assign o_rect.right_x      = r_out.right_x;
    assign o_rect.bottom_y     = r_out.bottom_y;
    assign o_rect.last_of_char = r_out.last_of_char;

    // The row counter never points past the glyph while runs are scanned.
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_row <= LAST_ROW))
        else $error("row counter past last glyph row");

    // The cursor moves only when an item is taken or the character is finished.
    a_cursor_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!accept && r_state != S_ADV) |=> $stable(r_cursor))
        else $error("cursor changed outside accept or advance");

    // A character without a glyph goes straight to the cursor advance.
    a_unknown_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !lookup.hit) |=> (r_state == S_ADV))
        else $error("unknown character did not advance directly");

endmodule

// ===== hdl/glyph_run_rectangle_emitter.sv =====
// Top level: renders text characters as 5x7 glyph pixel-run rectangles.
// Characters are taken only in idle; a character is finished before the next one is taken.
// Each glyph row takes one glyph row memory read, then one rectangle per cycle for each run
// while the output is not stalled; unknown codes go straight to the cursor advance.
// Reset: synchronous active low; clears the cursor, sets cell size to 32, then a
// sweep fills the glyph row memory before the first item is taken.
module glyph_run_rectangle_emitter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [grre_pkg::CFG_AW-1:0] paddr,
    input  logic [grre_pkg::CFG_DW-1:0] pwdata,
    output logic [grre_pkg::CFG_DW-1:0] prdata,
    output logic                        pready,
    grre_char_if.sink                   i_char,
    grre_rect_if.source                 o_rect
);

    logic [grre_pkg::CELL_W-1:0]     cell_size;
    grre_pkg::t_rom_req              rom_req;
    logic [grre_pkg::GLYPH_COLS-1:0] rom_rdata;

    // Configuration registers.
    grre_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_cell_size (cell_size)
    );

    // Glyph row memory.
    grre_ram #(
        .WIDTH (grre_pkg::GLYPH_COLS),
        .DEPTH (grre_pkg::ROM_DEPTH)
    ) u_rom (
        .i_clk   (i_clk),
        .i_we    (rom_req.we),
        .i_waddr (rom_req.waddr),
        .i_wdata (rom_req.wdata),
        .i_raddr (rom_req.raddr),
        .o_rdata (rom_rdata)
    );

    // Row scan and rectangle sequencer.
    grre_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cell_size (cell_size),
        .i_char      (i_char),
        .o_rect      (o_rect),
        .o_rom_req   (rom_req),
        .i_rom_rdata (rom_rdata)
    );

endmodule
